### hw/rtl/hnst_pkg.sv
// ----------------------------------------------------------------------------
// hnst_pkg
// Shared types and constants for the held-note slot tracker.
// ----------------------------------------------------------------------------
package hnst_pkg;

    localparam int SLOTS  = 16;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FUNC_W = 2;
    localparam int CH_W   = 4;
    localparam int NOTE_W = 7;
    localparam int STAT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_PRESS   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_FLUSH   = 2'd2
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_HELD       = 3'd1,
        ST_FULL       = 3'd2,
        ST_REL_FOUND  = 3'd3,
        ST_REL_MISS   = 3'd4,
        ST_FLUSH_OFF  = 3'd5,
        ST_FLUSH_NONE = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_REPLY,
        CS_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic reply;
        logic flush;
    } ctl_cmd_t;

    typedef struct packed {
        func_t in_func;
        logic  scan_done;
        logic  out_free;
        logic  flush_done;
    } dp_stat_t;

endpackage

### hw/rtl/hnst_ctrl.sv
// ----------------------------------------------------------------------------
// hnst_ctrl
// Sequencer: takes a word, runs the slot scan and reply or the flush; drops an unused code.
// ----------------------------------------------------------------------------
module hnst_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hnst_pkg::dp_stat_t stat,
    output hnst_pkg::ctl_cmd_t cmd
);

    hnst_pkg::ctrl_state_t state_reg;
    hnst_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hnst_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            hnst_pkg::CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (stat.in_func)
                        hnst_pkg::FN_PRESS:   state_next = hnst_pkg::CS_SCAN;
                        hnst_pkg::FN_RELEASE: state_next = hnst_pkg::CS_SCAN;
                        hnst_pkg::FN_FLUSH:   state_next = hnst_pkg::CS_FLUSH;
                        default:              state_next = hnst_pkg::CS_IDLE;
                    endcase
                end
            end
            hnst_pkg::CS_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = hnst_pkg::CS_REPLY;
                end
            end
            hnst_pkg::CS_REPLY: begin
                cmd.reply = 1'b1;
                if (stat.out_free) begin
                    state_next = hnst_pkg::CS_IDLE;
                end
            end
            hnst_pkg::CS_FLUSH: begin
                cmd.flush = 1'b1;
                if (stat.flush_done) begin
                    state_next = hnst_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = hnst_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/hnst_dp.sv
// ----------------------------------------------------------------------------
// hnst_dp
// Slot table, scan index, match and free-slot search, result register.
// ----------------------------------------------------------------------------
module hnst_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  hnst_pkg::ctl_cmd_t          cmd,
    output hnst_pkg::dp_stat_t          stat,
    input  logic [hnst_pkg::FUNC_W-1:0] s_func,
    input  logic [hnst_pkg::CH_W-1:0]   s_channel,
    input  logic [hnst_pkg::NOTE_W-1:0] s_note,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hnst_pkg::STAT_W-1:0] m_status,
    output logic [hnst_pkg::CH_W-1:0]   m_out_channel,
    output logic [hnst_pkg::NOTE_W-1:0] m_out_note,
    output logic                        m_last
);

    logic [hnst_pkg::SLOTS-1:0]  valid_reg,  valid_next;
    logic [hnst_pkg::CH_W-1:0]   slot_ch_reg   [hnst_pkg::SLOTS];
    logic [hnst_pkg::CH_W-1:0]   slot_ch_next  [hnst_pkg::SLOTS];
    logic [hnst_pkg::NOTE_W-1:0] slot_nt_reg   [hnst_pkg::SLOTS];
    logic [hnst_pkg::NOTE_W-1:0] slot_nt_next  [hnst_pkg::SLOTS];

    hnst_pkg::func_t             func_reg,   func_next;
    logic [hnst_pkg::CH_W-1:0]   ch_reg,     ch_next;
    logic [hnst_pkg::NOTE_W-1:0] nt_reg,     nt_next;
    logic [hnst_pkg::SLOT_W-1:0] idx_reg,    idx_next;
    logic                        hit_reg,    hit_next;
    logic [hnst_pkg::SLOT_W-1:0] hit_idx_reg, hit_idx_next;
    logic                        free_reg,   free_next;
    logic [hnst_pkg::SLOT_W-1:0] free_idx_reg, free_idx_next;

    logic                        m_valid_reg, m_valid_next;
    hnst_pkg::status_t           m_status_reg, m_status_next;
    logic [hnst_pkg::CH_W-1:0]   m_ch_reg,   m_ch_next;
    logic [hnst_pkg::NOTE_W-1:0] m_nt_reg,   m_nt_next;
    logic                        m_last_reg, m_last_next;

    logic                        out_free;
    logic                        cur_valid;
    logic                        any_held;
    logic                        more_above;
    logic                        cur_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_ch_reg  <= slot_ch_next;
        slot_nt_reg  <= slot_nt_next;
        func_reg     <= func_next;
        ch_reg       <= ch_next;
        nt_reg       <= nt_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        m_status_reg <= m_status_next;
        m_ch_reg     <= m_ch_next;
        m_nt_reg     <= m_nt_next;
        m_last_reg   <= m_last_next;
    end

    // status toward the sequencer and slot lookups at the scan index
    always_comb begin
        out_free   = !m_valid_reg || m_ready;
        cur_valid  = valid_reg[idx_reg];
        any_held   = |valid_reg;
        cur_match  = cur_valid && (slot_ch_reg[idx_reg] == ch_reg)
                     && (slot_nt_reg[idx_reg] == nt_reg);
        more_above = 1'b0;
        for (int j = 0; j < hnst_pkg::SLOTS; j++) begin
            if (j > int'(idx_reg)) begin
                more_above = more_above | valid_reg[j];
            end
        end
        stat.in_func    = hnst_pkg::func_t'(s_func);
        stat.scan_done  = (idx_reg == hnst_pkg::SLOT_W'(hnst_pkg::SLOTS - 1));
        stat.out_free   = out_free;
        stat.flush_done = out_free && (!any_held || (cur_valid && !more_above));
    end

    always_comb begin
        valid_next    = valid_reg;
        slot_ch_next  = slot_ch_reg;
        slot_nt_next  = slot_nt_reg;
        func_next     = func_reg;
        ch_next       = ch_reg;
        nt_next       = nt_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_ch_next     = m_ch_reg;
        m_nt_next     = m_nt_reg;
        m_last_next   = m_last_reg;

        if (cmd.load) begin
            func_next = hnst_pkg::func_t'(s_func);
            ch_next   = s_channel;
            nt_next   = s_note;
            idx_next  = '0;
            hit_next  = 1'b0;
            free_next = 1'b0;
        end

        if (cmd.scan) begin
            if (cur_match && !hit_reg) begin
                hit_next     = 1'b1;
                hit_idx_next = idx_reg;
            end
            if (!cur_valid && !free_reg) begin
                free_next     = 1'b1;
                free_idx_next = idx_reg;
            end
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.reply && out_free) begin
            m_valid_next = 1'b1;
            m_ch_next    = ch_reg;
            m_nt_next    = nt_reg;
            m_last_next  = 1'b1;
            if (func_reg == hnst_pkg::FN_PRESS) begin
                if (hit_reg) begin
                    m_status_next = hnst_pkg::ST_HELD;
                end else if (free_reg) begin
                    m_status_next               = hnst_pkg::ST_INSERTED;
                    valid_next[free_idx_reg]    = 1'b1;
                    slot_ch_next[free_idx_reg]  = ch_reg;
                    slot_nt_next[free_idx_reg]  = nt_reg;
                end else begin
                    m_status_next = hnst_pkg::ST_FULL;
                end
            end else begin
                if (hit_reg) begin
                    m_status_next           = hnst_pkg::ST_REL_FOUND;
                    valid_next[hit_idx_reg] = 1'b0;
                end else begin
                    m_status_next = hnst_pkg::ST_REL_MISS;
                end
            end
        end

        if (cmd.flush) begin
            if (!any_held) begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = hnst_pkg::ST_FLUSH_NONE;
                    m_ch_next     = '0;
                    m_nt_next     = '0;
                    m_last_next   = 1'b1;
                end
            end else if (cur_valid) begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_status_next       = hnst_pkg::ST_FLUSH_OFF;
                    m_ch_next           = slot_ch_reg[idx_reg];
                    m_nt_next           = slot_nt_reg[idx_reg];
                    m_last_next         = !more_above;
                    valid_next[idx_reg] = 1'b0;
                    idx_next            = idx_reg + 1'b1;
                end
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_channel = m_ch_reg;
    assign m_out_note    = m_nt_reg;
    assign m_last        = m_last_reg;

endmodule

### hw/rtl/held_note_slot_tracker.sv
// ----------------------------------------------------------------------------
// held_note_slot_tracker
// Press, release and flush of held notes over a fixed table of slots.
// ----------------------------------------------------------------------------
// press or release: a one-slot-per-cycle scan of the table, then a reply state
//   that registers the result once the output is free; no new word is taken meanwhile
// flush: one note-off per cycle per held slot while the output is free, empty
//   slots skipped at one per cycle; an empty table gives one word
// reset clears the control state, the output valid flag and every slot's
//   valid mark; slot channel and note contents are left as they were
module held_note_slot_tracker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hnst_pkg::FUNC_W-1:0] s_func,
    input  logic [hnst_pkg::CH_W-1:0]   s_channel,
    input  logic [hnst_pkg::NOTE_W-1:0] s_note,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hnst_pkg::STAT_W-1:0] m_status,
    output logic [hnst_pkg::CH_W-1:0]   m_out_channel,
    output logic [hnst_pkg::NOTE_W-1:0] m_out_note,
    output logic                        m_last
);

    hnst_pkg::ctl_cmd_t cmd;
    hnst_pkg::dp_stat_t stat;

    hnst_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hnst_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_func        (s_func),
        .s_channel     (s_channel),
        .s_note        (s_note),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_channel (m_out_channel),
        .m_out_note    (m_out_note),
        .m_last        (m_last)
    );

    // press and release replies are single words
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != hnst_pkg::ST_FLUSH_OFF) |-> m_last)
        else $error("single-word reply without last");

    // status codes stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= hnst_pkg::ST_FLUSH_NONE))
        else $error("status code out of range");

    // a press or release keeps the block busy for the scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && ((s_func == hnst_pkg::FN_PRESS) || (s_func == hnst_pkg::FN_RELEASE))
        |=> !s_ready)
        else $error("input taken during slot scan");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for held_note_slot_tracker. Press, release and flush
// words go in over a valid/ready channel with random gaps. A local copy of
// the slot table predicts every result word. Results are taken under random
// back-pressure and compared field by field, in order. Directed cases cover
// the empty flush, held and missing pairs, a full table, slot reuse and the
// ignored function code. Random segments then vary the press/release mix.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hnst_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int MAX_SHOWN   = 10;
    localparam int TAIL_CYCLES = 4 * (SLOTS + 2);
    localparam int POOL_SIZE   = 24;

    typedef struct packed {
        status_t             status;
        logic [CH_W-1:0]     ch;
        logic [NOTE_W-1:0]   nt;
        logic                last;
    } note_word_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func        = '0;
    logic [CH_W-1:0]     s_channel     = '0;
    logic [NOTE_W-1:0]   s_note        = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [STAT_W-1:0]   m_status;
    logic [CH_W-1:0]     m_out_channel;
    logic [NOTE_W-1:0]   m_out_note;
    logic                m_last;

    bit                  gaps_on = 1'b1;
    int                  err_cnt = 0;
    note_word_t          due_words[$];

    bit                  held_v[SLOTS];
    logic [CH_W-1:0]     held_ch[SLOTS];
    logic [NOTE_W-1:0]   held_nt[SLOTS];
    logic [CH_W-1:0]     pool_ch[POOL_SIZE];
    logic [NOTE_W-1:0]   pool_nt[POOL_SIZE];

    held_note_slot_tracker u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_channel     (s_channel),
        .s_note        (s_note),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_channel (m_out_channel),
        .m_out_note    (m_out_note),
        .m_last        (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic void report(string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN) $display("[%0t] %s", $time, msg);
    endfunction

    function automatic void owe(status_t st, logic [CH_W-1:0] ch, logic [NOTE_W-1:0] nt,
                                logic lst);
        note_word_t w;
        w.status = st;
        w.ch     = ch;
        w.nt     = nt;
        w.last   = lst;
        due_words.push_back(w);
    endfunction

    function automatic int find_held(logic [CH_W-1:0] ch, logic [NOTE_W-1:0] nt);
        for (int i = 0; i < SLOTS; i++) begin
            if (held_v[i] && held_ch[i] == ch && held_nt[i] == nt) return i;
        end
        return -1;
    endfunction

    // updates the slot table copy and queues the words this event causes
    function automatic void track_event(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] ch,
                                        logic [NOTE_W-1:0] nt);
        int hit;
        int free_slot;
        int top;
        hit       = find_held(ch, nt);
        free_slot = -1;
        top       = -1;
        if (fn == FN_PRESS) begin
            if (hit >= 0) begin
                owe(ST_HELD, ch, nt, 1'b1);
            end else begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!held_v[i]) free_slot = i;
                end
                if (free_slot >= 0) begin
                    held_v[free_slot]  = 1'b1;
                    held_ch[free_slot] = ch;
                    held_nt[free_slot] = nt;
                    owe(ST_INSERTED, ch, nt, 1'b1);
                end else begin
                    owe(ST_FULL, ch, nt, 1'b1);
                end
            end
        end else if (fn == FN_RELEASE) begin
            if (hit >= 0) begin
                held_v[hit] = 1'b0;
                owe(ST_REL_FOUND, ch, nt, 1'b1);
            end else begin
                owe(ST_REL_MISS, ch, nt, 1'b1);
            end
        end else if (fn == FN_FLUSH) begin
            for (int i = 0; i < SLOTS; i++) begin
                if (held_v[i]) top = i;
            end
            if (top < 0) begin
                owe(ST_FLUSH_NONE, '0, '0, 1'b1);
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (held_v[i]) begin
                        owe(ST_FLUSH_OFF, held_ch[i], held_nt[i], i == top);
                        held_v[i] = 1'b0;
                    end
                end
            end
        end
    endfunction

    task automatic send_word(logic [FUNC_W-1:0] fn, logic [CH_W-1:0] ch,
                             logic [NOTE_W-1:0] nt);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_func    <= fn;
        s_channel <= ch;
        s_note    <= nt;
        do @(posedge aclk); while (!s_ready);
        track_event(fn, ch, nt);
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_words.size() != 0);
    endtask

    function automatic void pick_pair(bit from_held, output logic [CH_W-1:0] ch,
                                      output logic [NOTE_W-1:0] nt);
        int live[$];
        int k;
        for (int i = 0; i < SLOTS; i++) begin
            if (held_v[i]) live.push_back(i);
        end
        if (from_held && live.size() > 0) begin
            k  = live[$urandom_range(0, live.size() - 1)];
            ch = held_ch[k];
            nt = held_nt[k];
        end else if ($urandom_range(0, 3) != 0) begin
            k  = $urandom_range(0, POOL_SIZE - 1);
            ch = pool_ch[k];
            nt = pool_nt[k];
        end else begin
            ch = 4'($urandom_range(0, 15));
            nt = 7'($urandom_range(0, 127));
        end
    endfunction

    task automatic test_directed();
        send_word(FN_FLUSH, 4'd15, 7'd127);
        send_word(FN_PRESS, 4'd0, 7'd0);
        send_word(FN_PRESS, 4'd15, 7'd127);
        send_word(FN_PRESS, 4'd0, 7'd0);
        send_word(FN_RELEASE, 4'd5, 7'd64);
        send_word(FN_UNUSED, 4'd15, 7'd127);
        send_word(FN_PRESS, 4'd0, 7'd127);
        send_word(FN_PRESS, 4'd15, 7'd0);
        send_word(FN_RELEASE, 4'd15, 7'd127);
        // hole left by the release is filled first, then the table fills up
        for (int i = 0; i < SLOTS - 3; i++) begin
            send_word(FN_PRESS, 4'(i), 7'(20 + i));
        end
        send_word(FN_PRESS, 4'd9, 7'd99);
        send_word(FN_RELEASE, 4'd2, 7'd22);
        send_word(FN_PRESS, 4'd9, 7'd99);
        send_word(FN_FLUSH, 4'd0, 7'd0);
    endtask

    task automatic test_random_mix(int n);
        int                sent;
        int                seg_len;
        int                press_pct;
        int                r;
        bit                from_held;
        logic [FUNC_W-1:0] fn;
        logic [CH_W-1:0]   ch;
        logic [NOTE_W-1:0] nt;
        sent = 0;
        while (sent < n) begin
            seg_len   = $urandom_range(20, 50);
            press_pct = $urandom_range(35, 85);
            for (int k = 0; k < seg_len && sent < n; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) fn = FN_UNUSED;
                else if (r < 3 + press_pct) fn = FN_PRESS;
                else if (r < 96) fn = FN_RELEASE;
                else fn = FN_FLUSH;
                if (fn == FN_RELEASE) from_held = $urandom_range(0, 9) < 7;
                else from_held = $urandom_range(0, 9) < 2;
                pick_pair(from_held, ch, nt);
                send_word(fn, ch, nt);
                sent++;
            end
            if ($urandom_range(0, 1) != 0) begin
                send_word(FN_FLUSH, 4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)));
                sent++;
            end
        end
    endtask

    task automatic test_drain_pause();
        wait_drain();
        test_random_mix(30);
        wait_drain();
        send_word(FN_FLUSH, 4'd0, 7'd0);
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_mix(40);
        gaps_on = 1'b1;
    endtask

    initial begin : result_sink
        int         stall;
        note_word_t want;
        note_word_t got;
        wait (aresetn === 1'b1);
        forever begin
            stall = gaps_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got.status = status_t'(m_status);
            got.ch     = m_out_channel;
            got.nt     = m_out_note;
            got.last   = m_last;
            if (due_words.size() == 0) begin
                report($sformatf("unexpected word: status %0d ch %0d note %0d last %0d",
                                 got.status, got.ch, got.nt, got.last));
            end else begin
                want = due_words.pop_front();
                if (got !== want) begin
                    report($sformatf({"mismatch: exp status %0d ch %0d note %0d last %0d,",
                                      " got status %0d ch %0d note %0d last %0d"},
                                     want.status, want.ch, want.nt, want.last,
                                     got.status, got.ch, got.nt, got.last));
                end
            end
        end
    end

    initial begin : stimulus
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_ch[i] = 4'($urandom_range(0, 15));
            pool_nt[i] = 7'($urandom_range(0, 127));
        end
        pool_ch[0] = 4'd0;
        pool_nt[0] = 7'd0;
        pool_ch[1] = 4'd15;
        pool_nt[1] = 7'd127;
        pool_ch[2] = 4'd0;
        pool_nt[2] = 7'd127;
        pool_ch[3] = 4'd15;
        pool_nt[3] = 7'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_mix(140);
        test_drain_pause();
        test_back_to_back();
        test_random_mix(140);
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0 && due_words.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
